// ----- src/sed_pkg.sv -----
// Shared types, constants and helper functions for the serpentine
// error diffusion halftoner. No dependencies.
package sed_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;

    localparam int NUM_CH  = 3;
    localparam int PIX_W   = 8;
    localparam int ERR_W   = 10;
    localparam int SHARE_W = 8;
    localparam int SUM_W   = 12;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int LINE_WIDTH_W = 11;
    localparam int THRESHOLD_W  = 8;
    localparam int CH_COUNT_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET    = 11'd512;
    localparam logic [THRESHOLD_W-1:0]  THRESHOLD_RESET     = 8'd127;
    localparam logic [CH_COUNT_W-1:0]   CHANNEL_COUNT_RESET = 2'd3;

    localparam logic [PIX_W-1:0] DOT_ON  = 8'hFF;
    localparam logic [PIX_W-1:0] DOT_OFF = 8'h00;

    // Floyd-Steinberg weights in sixteenths
    localparam logic [3:0] K_AHEAD       = 4'd7;
    localparam logic [3:0] K_BEHIND      = 4'd3;
    localparam logic [3:0] K_BELOW       = 4'd5;
    localparam logic [3:0] K_AHEAD_BELOW = 4'd1;

    localparam logic signed [SUM_W-1:0] ERR_HI = 12'sd511;
    localparam logic signed [SUM_W-1:0] ERR_LO = -12'sd512;

    typedef struct packed {
        logic frame_start;
        logic first_row;
        logic has_behind;
        logic last;
    } scan_flags_t;

    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SUM_W-1:0] v);
        logic signed [ERR_W-1:0] r;
        if (v > ERR_HI)
            r = ERR_HI[ERR_W-1:0];
        else if (v < ERR_LO)
            r = ERR_LO[ERR_W-1:0];
        else
            r = v[ERR_W-1:0];
        return r;
    endfunction

    // round(e * k / 16), half away from zero
    function automatic logic signed [SHARE_W-1:0] share(input logic signed [ERR_W-1:0] e,
                                                       input logic [3:0] k);
        logic [ERR_W-1:0]   mag;
        logic [ERR_W+3:0]   prod;
        logic [SHARE_W-1:0] q;
        mag  = e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
        prod = {4'b0, mag} * {{ERR_W{1'b0}}, k} + (ERR_W+4)'(8);
        q    = prod[SHARE_W+3:4];
        return e[ERR_W-1] ? SHARE_W'(-q) : q;
    endfunction

endpackage

// ----- src/serpentine_error_diffusion_top.sv -----
// Channel    Handshake        Payload
// s_         tvalid/tready    tdata: sample_a, sample_b, sample_c; tuser: frame_start
// m_         tvalid/tready    tdata: dot_a, dot_b, dot_c; tlast: row_done
// cfg_       we               index, data (line_width, threshold_level, channel_count)
//
// One pixel per clock while stage one is not held; a result passes through stage one and then the output register.
// A right-to-left row start whose behind column is not the previous pixel's column
// (width grown at the row turn) holds stage one while that column is read.
// Pending below-error and a write landing on the column being read are forwarded.
// Reset clears the control state only; the store needs no clearing pass.
// s_tready drops when stage one is held: output register full and not taken, or behind column being read.
// Depends on sed_pkg, sed_scan, sed_channel and sed_ram.
module serpentine_error_diffusion_top #(
    parameter int MAX_WIDTH = sed_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // sample_a, sample_b, sample_c
    input  logic                                s_tuser,   // frame_start
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // dot_a, dot_b, dot_c
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [sed_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sed_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int NUM_CH  = sed_pkg::NUM_CH;
    localparam int ERR_W   = sed_pkg::ERR_W;
    localparam int SHARE_W = sed_pkg::SHARE_W;
    localparam int PIX_W   = sed_pkg::PIX_W;
    localparam int WORD_W  = NUM_CH * ERR_W;

    // configuration
    logic [sed_pkg::LINE_WIDTH_W-1:0] line_width_reg;
    logic [sed_pkg::THRESHOLD_W-1:0]  threshold_reg;
    logic [sed_pkg::CH_COUNT_W-1:0]   ch_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= sed_pkg::LINE_WIDTH_RESET;
            threshold_reg  <= sed_pkg::THRESHOLD_RESET;
            ch_count_reg   <= sed_pkg::CHANNEL_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sed_pkg::REG_LINE_WIDTH:
                    line_width_reg <= cfg_data[sed_pkg::LINE_WIDTH_W-1:0];
                sed_pkg::REG_THRESHOLD:
                    threshold_reg <= cfg_data[sed_pkg::THRESHOLD_W-1:0];
                sed_pkg::REG_CHANNEL_COUNT:
                    ch_count_reg <= cfg_data[sed_pkg::CH_COUNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // input side
    logic                 in_accept, advance, need_fix;
    logic [COL_W-1:0]     scan_col, scan_behind;
    sed_pkg::scan_flags_t scan_flags;

    assign in_accept = s_tvalid && s_tready;

    sed_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .frame_start (s_tuser),
        .line_width  (line_width_reg),
        .col         (scan_col),
        .behind      (scan_behind),
        .flags       (scan_flags)
    );

    // stage 1: input register, aligned with the RAM read data
    logic                 s1_valid_reg, s1_valid_next;
    logic                 fix_done_reg, fix_done_next;
    logic [COL_W-1:0]     s1_col_reg, s1_behind_reg;
    sed_pkg::scan_flags_t s1_flags_reg;
    logic [23:0]          s1_samples_reg;

    assign advance       = s1_valid_reg && !need_fix && (!m_tvalid || m_tready);
    assign s_tready      = !s1_valid_reg || advance;
    assign s1_valid_next = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign fix_done_next = need_fix ? 1'b1 : (advance ? 1'b0 : fix_done_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fix_done_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            fix_done_reg <= fix_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_col_reg     <= scan_col;
            s1_behind_reg  <= scan_behind;
            s1_flags_reg   <= scan_flags;
            s1_samples_reg <= s_tdata;
        end
    end

    // row error store
    logic                ram_we, ram_re;
    logic [COL_W-1:0]    ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_wdata, ram_rdata;
    logic                wr_hit_reg;
    logic [WORD_W-1:0]   wr_data_reg;

    sed_ram #(.DATA_W(WORD_W), .DEPTH(MAX_WIDTH)) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_re    = in_accept || need_fix;
    assign ram_raddr = need_fix ? s1_behind_reg : scan_col;

    // write landing on the column read by this transaction
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            wr_hit_reg  <= ram_we && (ram_waddr == scan_col);
            wr_data_reg <= ram_wdata;
        end
    end

    // pending below-error of the previous pixel, written when finished
    logic                      pend_valid_reg;
    logic [COL_W-1:0]          pend_addr_reg;
    logic signed [ERR_W-1:0]   pend_val_reg [NUM_CH];
    logic signed [SHARE_W-1:0] ca_reg [NUM_CH];
    logic signed [SHARE_W-1:0] cab_reg [NUM_CH];
    logic signed [ERR_W-1:0]   own_reg [NUM_CH];

    logic                      pend_hit;
    logic [1:0]                ch_used;
    logic signed [ERR_W-1:0]   stored_pre [NUM_CH];
    logic signed [ERR_W-1:0]   stored [NUM_CH];
    logic signed [ERR_W-1:0]   prev_sel [NUM_CH];
    logic signed [ERR_W-1:0]   behind_val [NUM_CH];
    logic signed [ERR_W-1:0]   below_val [NUM_CH];
    logic signed [SHARE_W-1:0] ca_next [NUM_CH];
    logic signed [SHARE_W-1:0] cab_next [NUM_CH];
    logic [PIX_W-1:0]          dot [NUM_CH];

    assign pend_hit = pend_valid_reg && (pend_addr_reg == s1_col_reg);
    assign ch_used  = (ch_count_reg == '0) ? 2'd1 : ch_count_reg;
    assign need_fix = s1_valid_reg && s1_flags_reg.has_behind && !fix_done_reg
                      && !(pend_valid_reg && (pend_addr_reg == s1_behind_reg));

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_ch
        assign stored_pre[ch] = pend_hit ? pend_val_reg[ch]
                                         : (wr_hit_reg ? wr_data_reg[ch*ERR_W +: ERR_W]
                                                       : ram_rdata[ch*ERR_W +: ERR_W]);
        assign stored[ch]   = fix_done_reg ? own_reg[ch] : stored_pre[ch];
        assign prev_sel[ch] = fix_done_reg ? ram_rdata[ch*ERR_W +: ERR_W] : pend_val_reg[ch];
        assign ram_wdata[ch*ERR_W +: ERR_W] = (s1_flags_reg.has_behind && !need_fix)
                                              ? behind_val[ch] : pend_val_reg[ch];

        sed_channel u_channel (
            .sample            (s1_samples_reg[ch*PIX_W +: PIX_W]),
            .stored            (stored[ch]),
            .carry_ahead       (ca_reg[ch]),
            .carry_ahead_below (cab_reg[ch]),
            .pend_prev         (prev_sel[ch]),
            .threshold         (threshold_reg),
            .enable            (2'(ch) < ch_used),
            .use_store         (!s1_flags_reg.first_row),
            .use_carry         (!s1_flags_reg.frame_start),
            .last              (s1_flags_reg.last),
            .dot               (dot[ch]),
            .behind_val        (behind_val[ch]),
            .below_val         (below_val[ch]),
            .ahead_next        (ca_next[ch]),
            .ahead_below_next  (cab_next[ch])
        );
    end

    assign ram_we    = (advance && (s1_flags_reg.has_behind || pend_valid_reg))
                       || (need_fix && pend_valid_reg);
    assign ram_waddr = (s1_flags_reg.has_behind && !need_fix) ? s1_behind_reg : pend_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                ca_reg[i]  <= '0;
                cab_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            pend_valid_reg <= 1'b1;
            for (int i = 0; i < NUM_CH; i++)
            begin
                ca_reg[i]  <= ca_next[i];
                cab_reg[i] <= cab_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pend_addr_reg <= s1_col_reg;
            for (int i = 0; i < NUM_CH; i++)
            begin
                pend_val_reg[i] <= below_val[i];
            end
        end
    end

    // own column error held while the behind column is read
    always_ff @(posedge clk)
    begin
        if (need_fix)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                own_reg[i] <= stored_pre[i];
            end
        end
    end

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [23:0]      out_data_reg;
    logic             out_last_reg;

    assign out_valid_next = advance ? 1'b1 : ((out_valid_reg && m_tready) ? 1'b0
                                                                         : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {dot[2], dot[1], dot[0]};
            out_last_reg <= s1_flags_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_behind_is_pending: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_flags_reg.has_behind && !fix_done_reg
        |-> pend_valid_reg && pend_addr_reg == s1_behind_reg)
        else $error("behind column does not match pending entry");

    a_no_write_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !need_fix && m_tvalid && !m_tready |-> !ram_we)
        else $error("row store written while stage is stalled");

    a_result_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s1_valid_reg))
        else $error("result appeared without a pixel in stage one");

endmodule

// ----- src/sed_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sed_ram #(
    parameter int DATA_W = 30,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sed_scan.sv -----
// Serpentine column sequencer: tracks column, scan direction and first row,
// and decodes row end and neighbor columns. Depends on sed_pkg.
module sed_scan #(
    parameter int MAX_WIDTH = sed_pkg::MAX_WIDTH_DEFAULT,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                frame_start,
    input  logic [sed_pkg::LINE_WIDTH_W-1:0]    line_width,
    output logic [COL_W-1:0]                    col,
    output logic [COL_W-1:0]                    behind,
    output sed_pkg::scan_flags_t                flags
);

    localparam int LW = (COL_W + 1 > sed_pkg::LINE_WIDTH_W) ? COL_W + 1
                                                            : sed_pkg::LINE_WIDTH_W;

    logic [COL_W-1:0] col_reg, col_next;
    logic             rev_reg, rev_next;
    logic             first_row_reg, first_row_next;

    logic [COL_W-1:0] c, ahead;
    logic             rev, first, last, has_behind;
    logic [LW-1:0]    lw, w, c_ext;

    always_comb
    begin
        c     = frame_start ? '0 : col_reg;
        rev   = frame_start ? 1'b0 : rev_reg;
        first = frame_start | first_row_reg;
        lw    = LW'(line_width);
        if (lw == '0)
            w = LW'(1);
        else if (lw > LW'(MAX_WIDTH))
            w = LW'(MAX_WIDTH);
        else
            w = lw;
        c_ext = LW'(c);
        if (rev)
        begin
            last       = (c == '0);
            has_behind = (c_ext + LW'(1)) < w;
            ahead      = c - COL_W'(1);
            behind     = c + COL_W'(1);
        end
        else
        begin
            last       = (c_ext + LW'(1)) >= w;
            has_behind = (c != '0);
            ahead      = c + COL_W'(1);
            behind     = c - COL_W'(1);
        end

        col_next       = col_reg;
        rev_next       = rev_reg;
        first_row_next = first_row_reg;
        if (accept)
        begin
            if (last)
            begin
                rev_next       = !rev;
                first_row_next = 1'b0;
                col_next       = !rev ? COL_W'(w - LW'(1)) : '0;
            end
            else
            begin
                rev_next       = rev;
                first_row_next = first;
                col_next       = ahead;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            rev_reg       <= 1'b0;
            first_row_reg <= 1'b1;
        end
        else
        begin
            col_reg       <= col_next;
            rev_reg       <= rev_next;
            first_row_reg <= first_row_next;
        end
    end

    assign col               = c;
    assign flags.frame_start = frame_start;
    assign flags.first_row   = first;
    assign flags.has_behind  = has_behind;
    assign flags.last        = last;

    a_row_end_turns: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !frame_start && last |=> rev_reg != $past(rev_reg))
        else $error("scan direction did not turn at row end");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(col_reg) < LW'(MAX_WIDTH))
        else $error("column position beyond maximum width");

endmodule

// ----- src/sed_channel.sv -----
// Per-channel error diffusion datapath: adds pending error, clamps,
// thresholds and splits the error into rounded shares. Depends on sed_pkg.
module sed_channel (
    input  logic [sed_pkg::PIX_W-1:0]          sample,
    input  logic signed [sed_pkg::ERR_W-1:0]   stored,
    input  logic signed [sed_pkg::SHARE_W-1:0] carry_ahead,
    input  logic signed [sed_pkg::SHARE_W-1:0] carry_ahead_below,
    input  logic signed [sed_pkg::ERR_W-1:0]   pend_prev,
    input  logic [sed_pkg::THRESHOLD_W-1:0]    threshold,
    input  logic                               enable,
    input  logic                               use_store,
    input  logic                               use_carry,
    input  logic                               last,
    output logic [sed_pkg::PIX_W-1:0]          dot,
    output logic signed [sed_pkg::ERR_W-1:0]   behind_val,
    output logic signed [sed_pkg::ERR_W-1:0]   below_val,
    output logic signed [sed_pkg::SHARE_W-1:0] ahead_next,
    output logic signed [sed_pkg::SHARE_W-1:0] ahead_below_next
);

    localparam int SUM_W   = sed_pkg::SUM_W;
    localparam int ERR_W   = sed_pkg::ERR_W;
    localparam int SHARE_W = sed_pkg::SHARE_W;
    localparam int PIX_W   = sed_pkg::PIX_W;

    logic signed [SUM_W-1:0]   st_x, ca_x, cab_x, pend, sum, prev_x;
    logic [PIX_W-1:0]          clamped, dot_raw;
    logic signed [ERR_W-1:0]   err;
    logic signed [SHARE_W-1:0] s_ahead, s_behind, s_below, s_ahead_below;

    always_comb
    begin
        st_x  = use_store ? {{(SUM_W-ERR_W){stored[ERR_W-1]}}, stored} : '0;
        ca_x  = use_carry ? {{(SUM_W-SHARE_W){carry_ahead[SHARE_W-1]}}, carry_ahead} : '0;
        cab_x = use_carry ? {{(SUM_W-SHARE_W){carry_ahead_below[SHARE_W-1]}},
                             carry_ahead_below} : '0;
        pend  = st_x + ca_x;
        sum   = pend + $signed({{(SUM_W-PIX_W){1'b0}}, sample});

        if (sum[SUM_W-1])
            clamped = '0;
        else if (sum > $signed(SUM_W'(255)))
            clamped = 8'hFF;
        else
            clamped = sum[PIX_W-1:0];

        dot_raw = (clamped >= threshold) ? sed_pkg::DOT_ON : sed_pkg::DOT_OFF;
        err     = enable ? $signed({2'b00, clamped}) - $signed({2'b00, dot_raw}) : '0;

        s_ahead       = sed_pkg::share(err, sed_pkg::K_AHEAD);
        s_behind      = sed_pkg::share(err, sed_pkg::K_BEHIND);
        s_below       = sed_pkg::share(err, sed_pkg::K_BELOW);
        s_ahead_below = sed_pkg::share(err, sed_pkg::K_AHEAD_BELOW);

        prev_x     = {{(SUM_W-ERR_W){pend_prev[ERR_W-1]}}, pend_prev};
        behind_val = sed_pkg::sat_err(prev_x
                     + {{(SUM_W-SHARE_W){s_behind[SHARE_W-1]}}, s_behind});
        below_val  = enable ? sed_pkg::sat_err(cab_x
                     + {{(SUM_W-SHARE_W){s_below[SHARE_W-1]}}, s_below}) : '0;

        ahead_next       = last ? '0 : s_ahead;
        ahead_below_next = last ? '0 : s_ahead_below;
        dot              = enable ? dot_raw : sed_pkg::DOT_OFF;
    end

endmodule
